// ----- rtl/bprw_pkg.sv -----
// Shared types, constants and register codes for the blended pixel read/write block.
// Used by every module under rtl/ except bprw_bank_ram; depends on nothing else.
`timescale 1ns / 1ps

package bprw_pkg;

    // Field widths.
    localparam int BPP_W      = 3;
    localparam int PITCH_W    = 15;
    localparam int MASK_W     = 16;
    localparam int COORD_W    = 12;
    localparam int PIX_W      = 32;
    localparam int ALPHA_W    = 8;
    localparam int WEIGHT_W   = 9;

    // y*pitch + x*bpp fits in 27 bits, and so does address + bpp.
    localparam int ADDR_W     = 27;
    localparam int PROD_W     = COORD_W + PITCH_W;
    localparam int XOFF_W     = COORD_W + BPP_W;

    // A blend lane sum: 16-bit source times alpha plus 16-bit destination times (256 - alpha).
    localparam int LANE_W     = 25;
    localparam int NUM_LANES  = 3;

    // The frame store is split into four byte banks so a pixel at any byte address
    // is read or written in one access.
    localparam int NUM_BANKS  = 4;
    localparam int BANK_SEL_W = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 40;

    localparam int FRAME_BYTES_DEF = 16384;

    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd4;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 15'd256;
    localparam logic [MASK_W-1:0]  RED_RESET   = 16'hF800;
    localparam logic [MASK_W-1:0]  GREEN_RESET = 16'h07E0;
    localparam logic [MASK_W-1:0]  BLUE_RESET  = 16'h001F;

    localparam logic [BPP_W-1:0]    BPP_MIN      = 3'd1;
    localparam logic [BPP_W-1:0]    BPP_ONE      = 3'd1;
    localparam logic [BPP_W-1:0]    BPP_TWO      = 3'd2;
    localparam logic [BPP_W-1:0]    BPP_MAX      = 3'd4;
    localparam logic [ALPHA_W-1:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [WEIGHT_W-1:0] BLEND_ONE    = 9'd256;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPP   = 3'd0,
        CFG_PITCH = 3'd1,
        CFG_RED   = 3'd2,
        CFG_GREEN = 3'd3,
        CFG_BLUE  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [BPP_W-1:0]   bpp;
        logic [PITCH_W-1:0] pitch;
        logic [MASK_W-1:0]  red_mask;
        logic [MASK_W-1:0]  green_mask;
        logic [MASK_W-1:0]  blue_mask;
    } cfg_t;

    // Sequencer controls handed to the address unit.
    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } addr_ctl_t;

    // Address unit status back to the sequencer.
    typedef struct packed {
        logic fmt_ok;
        logic out_of_range;
    } addr_sts_t;

endpackage

// ----- rtl/bprw_bank_ram.sv -----
// One byte bank of the frame store: synchronous RAM, one write and one read port.
// Read data is registered. Depends on nothing else.
`timescale 1ns / 1ps

module bprw_bank_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bprw_addr_gen.sv -----
// Address unit: y*pitch and x*bpp in one stage, their sum in the next, then the range check.
// Depends on bprw_pkg.
`timescale 1ns / 1ps

module bprw_addr_gen #(
    parameter int FRAME_BYTES = bprw_pkg::FRAME_BYTES_DEF
) (
    input  logic                          clk,
    input  bprw_pkg::addr_ctl_t           ctl,
    input  bprw_pkg::cfg_t                cfg,
    input  logic [bprw_pkg::COORD_W-1:0]  x_coord,
    input  logic [bprw_pkg::COORD_W-1:0]  y_coord,
    output logic [bprw_pkg::ADDR_W-1:0]   addr,
    output bprw_pkg::addr_sts_t           sts
);

    localparam logic [bprw_pkg::ADDR_W-1:0] LIMIT = bprw_pkg::ADDR_W'(FRAME_BYTES);

    logic [bprw_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [bprw_pkg::XOFF_W-1:0] xoff_reg, xoff_next;
    logic [bprw_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [bprw_pkg::ADDR_W-1:0] end_addr;

    assign prod_next = bprw_pkg::PROD_W'(y_coord) * bprw_pkg::PROD_W'(cfg.pitch);
    assign xoff_next = bprw_pkg::XOFF_W'(x_coord) * bprw_pkg::XOFF_W'(cfg.bpp);
    assign addr_next = bprw_pkg::ADDR_W'(prod_reg) + bprw_pkg::ADDR_W'(xoff_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
            xoff_reg <= xoff_next;
        end
        if (ctl.sum_en)
        begin
            addr_reg <= addr_next;
        end
    end

    assign end_addr = addr_reg + bprw_pkg::ADDR_W'(cfg.bpp);

    assign addr             = addr_reg;
    assign sts.fmt_ok       = (cfg.bpp >= bprw_pkg::BPP_MIN) && (cfg.bpp <= bprw_pkg::BPP_MAX);
    assign sts.out_of_range = end_addr > LIMIT;

endmodule

// ----- rtl/bprw_blend_lane.sv -----
// One color lane of the blender: registers src*alpha + dst*(256 - alpha).
// Depends on bprw_pkg.
`timescale 1ns / 1ps

module bprw_blend_lane (
    input  logic                          clk,
    input  logic                          en,
    input  logic [bprw_pkg::MASK_W-1:0]   src,
    input  logic [bprw_pkg::MASK_W-1:0]   dst,
    input  logic [bprw_pkg::ALPHA_W-1:0]  alpha,
    output logic [bprw_pkg::LANE_W-1:0]   sum
);

    logic [bprw_pkg::WEIGHT_W-1:0] weight;
    logic [bprw_pkg::LANE_W-1:0]   sum_reg, sum_next;

    assign weight   = bprw_pkg::BLEND_ONE - bprw_pkg::WEIGHT_W'(alpha);
    assign sum_next = bprw_pkg::LANE_W'(src) * bprw_pkg::LANE_W'(alpha)
                    + bprw_pkg::LANE_W'(dst) * bprw_pkg::LANE_W'(weight);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sum = sum_reg;

endmodule

// ----- rtl/blended_pixel_read_write.sv -----
// Top level: pixel read / blended write port over a four-bank byte frame store.
// Depends on bprw_pkg, bprw_addr_gen, bprw_blend_lane and bprw_bank_ram.
//
//   Port group      Dir   Item fields (lowest bit first)
//   s_axis_*        in    mode, x_coord, y_coord, pixel_value
//   m_axis_*        out   read_data, addr_error
//   cfg_*           in    register index, write data (no read-back)
//
// An accepted item passes through the sequencer's stages multiply, address add, bank read,
// blend multiply and write-back before its result is in the output register; the blend
// stage is skipped when the address is out of range or the format is invalid. The next
// item is taken once the sequencer is back in idle.
// Reset clears the sequencer, the output valid flag and the configuration; the frame store
// is not cleared. A stalled output holds the sequencer in its write-back stage.
`timescale 1ns / 1ps

module blended_pixel_read_write #(
    parameter int FRAME_BYTES = bprw_pkg::FRAME_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] mode, [12:1] x_coord, [24:13] y_coord, [56:25] pixel_value, [63:57] zero
    input  logic [bprw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [31:0] read_data, [32] addr_error, [39:33] zero
    output logic [bprw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_we,
    input  logic [bprw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bprw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH = (FRAME_BYTES + bprw_pkg::NUM_BANKS - 1) / bprw_pkg::NUM_BANKS;
    localparam int RW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_SUM   = 6'b000100,
        ST_RD    = 6'b001000,
        ST_BLEND = 6'b010000,
        ST_FIN   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    bprw_pkg::cfg_t cfg_reg;

    logic                          mode_reg;
    logic [bprw_pkg::COORD_W-1:0]  x_reg;
    logic [bprw_pkg::COORD_W-1:0]  y_reg;
    logic [bprw_pkg::PIX_W-1:0]    pix_reg;
    logic                          err_reg;
    logic                          ok_reg;
    logic [bprw_pkg::PIX_W-1:0]    dst_reg;

    logic                          out_valid_reg;
    logic [bprw_pkg::PIX_W-1:0]    out_data_reg;
    logic                          out_err_reg;

    bprw_pkg::addr_ctl_t           addr_ctl;
    bprw_pkg::addr_sts_t           addr_sts;
    logic [bprw_pkg::ADDR_W-1:0]   addr;
    logic                          pix_ok;

    logic [bprw_pkg::BANK_SEL_W-1:0] lo;
    logic [RW-1:0]                   row_base;
    logic [RW-1:0]                   bank_row [bprw_pkg::NUM_BANKS];
    logic [7:0]                      bank_q   [bprw_pkg::NUM_BANKS];
    logic [7:0]                      bank_wd  [bprw_pkg::NUM_BANKS];
    logic                            bank_we  [bprw_pkg::NUM_BANKS];
    logic                            rd_en;

    logic [bprw_pkg::PIX_W-1:0]    dst_comb;
    logic [bprw_pkg::MASK_W-1:0]   lane_src [bprw_pkg::NUM_LANES];
    logic [bprw_pkg::MASK_W-1:0]   lane_dst [bprw_pkg::NUM_LANES];
    logic [bprw_pkg::LANE_W-1:0]   lane_sum [bprw_pkg::NUM_LANES];
    logic [bprw_pkg::MASK_W-1:0]   lane_mask [bprw_pkg::NUM_LANES];
    logic [bprw_pkg::ALPHA_W-1:0]  alpha;
    logic                          blend_en;

    logic [bprw_pkg::PIX_W-1:0]    val_word;
    logic                          out_free;
    logic                          fin_go;
    logic                          fin_write;
    logic                          accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bpp        <= bprw_pkg::BPP_RESET;
            cfg_reg.pitch      <= bprw_pkg::PITCH_RESET;
            cfg_reg.red_mask   <= bprw_pkg::RED_RESET;
            cfg_reg.green_mask <= bprw_pkg::GREEN_RESET;
            cfg_reg.blue_mask  <= bprw_pkg::BLUE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bprw_pkg::CFG_BPP:   cfg_reg.bpp        <= cfg_data[bprw_pkg::BPP_W-1:0];
                bprw_pkg::CFG_PITCH: cfg_reg.pitch      <= cfg_data[bprw_pkg::PITCH_W-1:0];
                bprw_pkg::CFG_RED:   cfg_reg.red_mask   <= cfg_data;
                bprw_pkg::CFG_GREEN: cfg_reg.green_mask <= cfg_data;
                bprw_pkg::CFG_BLUE:  cfg_reg.blue_mask  <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_axis_tdata[0];
            x_reg    <= s_axis_tdata[12:1];
            y_reg    <= s_axis_tdata[24:13];
            pix_reg  <= s_axis_tdata[56:25];
        end
    end

    assign addr_ctl.mul_en = (state_reg == ST_MUL);
    assign addr_ctl.sum_en = (state_reg == ST_SUM);

    bprw_addr_gen #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_addr_gen (
        .clk     (clk),
        .ctl     (addr_ctl),
        .cfg     (cfg_reg),
        .x_coord (x_reg),
        .y_coord (y_reg),
        .addr    (addr),
        .sts     (addr_sts)
    );

    assign pix_ok = addr_sts.fmt_ok && !addr_sts.out_of_range;

    // Status is sampled once the address is final; the sequencer keeps one item in flight,
    // so a write-back always lands before the next item's bank read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD)
        begin
            err_reg <= addr_sts.fmt_ok && addr_sts.out_of_range;
            ok_reg  <= pix_ok;
        end
    end

    // Byte i of the pixel sits in bank (addr + i) mod 4; banks below the start bank
    // take the next row.
    assign lo       = addr[bprw_pkg::BANK_SEL_W-1:0];
    assign row_base = addr[RW+1:2];
    assign rd_en    = (state_reg == ST_RD) && pix_ok;

    for (genvar b = 0; b < bprw_pkg::NUM_BANKS; b++)
    begin : g_bank
        logic [bprw_pkg::BANK_SEL_W-1:0] idx;

        assign bank_row[b] = row_base
                           + {{(RW-1){1'b0}}, (bprw_pkg::BANK_SEL_W'(b) < lo)};
        assign idx         = bprw_pkg::BANK_SEL_W'(b) - lo;
        assign bank_wd[b]  = val_word[8*idx +: 8];
        assign bank_we[b]  = fin_write && ({1'b0, idx} < cfg_reg.bpp);

        bprw_bank_ram #(
            .DEPTH (DEPTH),
            .AW    (RW)
        ) u_bank (
            .clk     (clk),
            .rd_en   (rd_en),
            .rd_addr (bank_row[b]),
            .rd_data (bank_q[b]),
            .wr_en   (bank_we[b]),
            .wr_addr (bank_row[b]),
            .wr_data (bank_wd[b])
        );
    end

    always_comb
    begin
        logic [bprw_pkg::BANK_SEL_W-1:0] sel;
        sel      = '0;
        dst_comb = '0;
        for (int i = 0; i < bprw_pkg::NUM_BANKS; i++)
        begin
            sel = lo + bprw_pkg::BANK_SEL_W'(i);
            if (bprw_pkg::BPP_W'(i) < cfg_reg.bpp)
            begin
                dst_comb[8*i +: 8] = bank_q[sel];
            end
        end
    end

    assign alpha    = pix_reg[31:24];
    assign blend_en = (state_reg == ST_BLEND);

    assign lane_mask[0] = cfg_reg.red_mask;
    assign lane_mask[1] = cfg_reg.green_mask;
    assign lane_mask[2] = cfg_reg.blue_mask;

    // The 16-bit format blends whole masked words; the wider formats blend byte lanes.
    for (genvar k = 0; k < bprw_pkg::NUM_LANES; k++)
    begin : g_lane
        assign lane_src[k] = (cfg_reg.bpp == bprw_pkg::BPP_TWO)
                           ? (pix_reg[15:0] & lane_mask[k])
                           : {8'h00, pix_reg[8*k +: 8]};
        assign lane_dst[k] = (cfg_reg.bpp == bprw_pkg::BPP_TWO)
                           ? (dst_comb[15:0] & lane_mask[k])
                           : {8'h00, dst_comb[8*k +: 8]};

        bprw_blend_lane u_lane (
            .clk   (clk),
            .en    (blend_en),
            .src   (lane_src[k]),
            .dst   (lane_dst[k]),
            .alpha (alpha),
            .sum   (lane_sum[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (blend_en)
        begin
            dst_reg <= dst_comb;
        end
    end

    always_comb
    begin
        if ((alpha == bprw_pkg::ALPHA_OPAQUE) || (cfg_reg.bpp == bprw_pkg::BPP_ONE))
        begin
            val_word = pix_reg;
        end
        else if (cfg_reg.bpp == bprw_pkg::BPP_TWO)
        begin
            val_word = {16'h0000,
                        (lane_sum[0][23:8] & cfg_reg.red_mask)
                      | (lane_sum[1][23:8] & cfg_reg.green_mask)
                      | (lane_sum[2][23:8] & cfg_reg.blue_mask)};
        end
        else
        begin
            val_word = {8'h00, lane_sum[2][15:8], lane_sum[1][15:8], lane_sum[0][15:8]};
        end
    end

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign fin_go    = (state_reg == ST_FIN) && out_free;
    assign fin_write = fin_go && ok_reg && (mode_reg == bprw_pkg::MODE_WRITE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_RD;
            ST_RD:    state_next = pix_ok ? ST_BLEND : ST_FIN;
            ST_BLEND: state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_data_reg <= (ok_reg && (mode_reg == bprw_pkg::MODE_READ)) ? dst_reg : '0;
            out_err_reg  <= err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_err_reg, out_data_reg};

endmodule

// ----- verif/blended_pixel_read_write_tb.sv -----
// Self-checking testbench for blended_pixel_read_write: pixel reads, direct writes and blends
// over the byte frame store, checked against a local pixel predictor. Needs rtl/bprw_pkg.sv
// and the block's RTL; it reads no files.
`timescale 1ns / 1ps

module blended_pixel_read_write_tb;

    import bprw_pkg::*;

    typedef longint unsigned u64_t;

    localparam int FRAME_SIZE  = FRAME_BYTES_DEF;
    localparam int IN_USED_W   = 1 + 2 * COORD_W + PIX_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int NUM_PHASES  = 15;
    localparam int VALID_ITEMS = 85;
    localparam int NOFMT_ITEMS = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam u64_t LANE_R_MASK = 64'h0000_00FF;
    localparam u64_t LANE_G_MASK = 64'h0000_FF00;
    localparam u64_t LANE_B_MASK = 64'h00FF_0000;

    // Pixel format per random phase, phase 0 is the rightmost entry. 0, 5, 6 and 7 are
    // not valid formats.
    localparam logic [NUM_PHASES-1:0][BPP_W-1:0] PHASE_BPP = {
        3'd4, 3'd7, 3'd2, 3'd5, 3'd1, 3'd2, 3'd3, 3'd0,
        3'd4, 3'd2, 3'd6, 3'd1, 3'd3, 3'd2, 3'd4
    };

    typedef struct packed {
        logic [PIX_W-1:0] read_data;
        logic             addr_error;
    } px_result_t;

    typedef struct packed {
        bit                 is_cfg;
        logic [BPP_W-1:0]   bpp;
        logic [PITCH_W-1:0] pitch;
        logic [MASK_W-1:0]  red;
        logic [MASK_W-1:0]  green;
        logic [MASK_W-1:0]  blue;
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
        bit                 fixed;
        logic [PIX_W-1:0]   want_data;
        logic               want_err;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [0] mode, [12:1] x_coord, [24:13] y_coord, [56:25] pixel_value, [63:57] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] read_data, [32] addr_error, [39:33] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: frame contents, which bytes hold data, and the register copy.
    bit   [7:0]         frame_mem   [FRAME_SIZE];
    bit                 frame_valid [FRAME_SIZE];
    logic [BPP_W-1:0]   fmt_bpp;
    logic [PITCH_W-1:0] fmt_pitch;
    logic [MASK_W-1:0]  fmt_red;
    logic [MASK_W-1:0]  fmt_green;
    logic [MASK_W-1:0]  fmt_blue;

    px_result_t pending_px[$];
    px_result_t oldest_px;
    dir_row_t   dir_rows[$];

    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 19;
    int  recv_idle_pct = 59;
    int  hold_left     = 0;
    bit  hold_armed    = 1'b0;
    bit  hold_done     = 1'b0;
    int  n_reads       = 0;
    int  n_writes      = 0;
    int  n_oor         = 0;
    int  n_settings    = 1;

    blended_pixel_read_write DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic u64_t blend_channel(input u64_t src, input u64_t dst, input u64_t mask,
                                           input u64_t a);
        return ((src & mask) * a + (dst & mask) * (u64_t'(BLEND_ONE) - a)) >> ALPHA_W;
    endfunction

    function automatic void predict_access(input logic mode, input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [PIX_W-1:0] pix,
                                           output px_result_t res);
        u64_t n;
        u64_t addr;
        u64_t dst;
        u64_t val;
        u64_t a;
        int   i;
        res = '0;
        n   = u64_t'(fmt_bpp);
        if (fmt_bpp < BPP_MIN || fmt_bpp > BPP_MAX)
            return;
        addr = u64_t'(y) * u64_t'(fmt_pitch) + u64_t'(x) * n;
        if (addr + n > FRAME_SIZE)
        begin
            res.addr_error = 1'b1;
            return;
        end
        dst = 0;
        for (i = 0; i < n; i++)
            dst |= u64_t'(frame_mem[addr + i]) << (8 * i);
        if (mode == MODE_READ)
        begin
            res.read_data = dst[PIX_W-1:0];
            return;
        end
        a = u64_t'(pix[PIX_W-1 -: ALPHA_W]);
        if (a == ALPHA_OPAQUE || fmt_bpp == BPP_ONE)
            val = u64_t'(pix);
        else if (fmt_bpp == BPP_TWO)
            val = (blend_channel(pix, dst, fmt_red, a) & fmt_red)
                | (blend_channel(pix, dst, fmt_green, a) & fmt_green)
                | (blend_channel(pix, dst, fmt_blue, a) & fmt_blue);
        else
            // Fixed byte lanes; the top byte of a 4-byte pixel comes out zero.
            val = (blend_channel(pix, dst, LANE_R_MASK, a) & LANE_R_MASK)
                | (blend_channel(pix, dst, LANE_G_MASK, a) & LANE_G_MASK)
                | (blend_channel(pix, dst, LANE_B_MASK, a) & LANE_B_MASK);
        for (i = 0; i < n; i++)
        begin
            frame_mem[addr + i]   = val[8 * i +: 8];
            frame_valid[addr + i] = 1'b1;
        end
    endfunction

    // Random item, mostly in a small window so that reads and blends land on written pixels.
    // Anything that would read a byte never written becomes an opaque write instead.
    function automatic void random_pixel(output logic mode, output logic [COORD_W-1:0] x,
                                         output logic [COORD_W-1:0] y,
                                         output logic [PIX_W-1:0] pix);
        int unsigned pick;
        int unsigned rows;
        int unsigned cols;
        u64_t        n;
        u64_t        addr;
        bit          covered;
        int          i;
        n    = u64_t'(fmt_bpp);
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            x = COORD_W'($urandom_range(7));
            y = COORD_W'($urandom_range(7));
        end
        else if (pick < 90)
        begin
            rows = FRAME_SIZE / fmt_pitch;
            cols = (fmt_bpp >= BPP_MIN && fmt_bpp <= BPP_MAX) ? 32'(u64_t'(fmt_pitch) / n)
                                                              : 32'(fmt_pitch);
            x = COORD_W'($urandom_range(cols > 4095 ? 4095 : cols));
            y = COORD_W'($urandom_range(rows > 4095 ? 4095 : rows));
        end
        else
        begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
        end
        mode = ($urandom_range(99) < 40) ? MODE_READ : MODE_WRITE;
        pix  = $urandom;
        pick = $urandom_range(99);
        if (mode == MODE_WRITE && pick < 30)
            pix[PIX_W-1 -: ALPHA_W] = ALPHA_OPAQUE;
        else if (mode == MODE_WRITE && pick < 40)
            pix[PIX_W-1 -: ALPHA_W] = '0;
        if (fmt_bpp >= BPP_MIN && fmt_bpp <= BPP_MAX
            && (mode == MODE_READ || (pix[PIX_W-1 -: ALPHA_W] != ALPHA_OPAQUE
                                      && fmt_bpp != BPP_ONE)))
        begin
            addr = u64_t'(y) * u64_t'(fmt_pitch) + u64_t'(x) * n;
            if (addr + n <= FRAME_SIZE)
            begin
                covered = 1'b1;
                for (i = 0; i < n; i++)
                    covered &= frame_valid[addr + i];
                if (!covered)
                begin
                    mode = MODE_WRITE;
                    pix[PIX_W-1 -: ALPHA_W] = ALPHA_OPAQUE;
                end
            end
        end
    endfunction

    function automatic void row_cfg(input logic [BPP_W-1:0] bpp, input logic [PITCH_W-1:0] pitch,
                                    input logic [MASK_W-1:0] red, input logic [MASK_W-1:0] green,
                                    input logic [MASK_W-1:0] blue);
        dir_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.bpp    = bpp;
        r.pitch  = pitch;
        r.red    = red;
        r.green  = green;
        r.blue   = blue;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_px(input logic mode, input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix);
        dir_row_t r;
        r      = '0;
        r.mode = mode;
        r.x    = x;
        r.y    = y;
        r.pix  = pix;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_fix(input logic mode, input logic [COORD_W-1:0] x,
                                    input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix,
                                    input logic [PIX_W-1:0] want_data, input logic want_err);
        dir_row_t r;
        r           = '0;
        r.mode      = mode;
        r.x         = x;
        r.y         = y;
        r.pix       = pix;
        r.fixed     = 1'b1;
        r.want_data = want_data;
        r.want_err  = want_err;
        dir_rows.push_back(r);
    endfunction

    // Called at a falling edge; leaves cfg_we high for the caller to lower.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_BPP:   fmt_bpp   = val[BPP_W-1:0];
            CFG_PITCH: fmt_pitch = val[PITCH_W-1:0];
            CFG_RED:   fmt_red   = val;
            CFG_GREEN: fmt_green = val;
            CFG_BLUE:  fmt_blue  = val;
            default:   ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [BPP_W-1:0] bpp, input logic [PITCH_W-1:0] pitch,
                                input logic [MASK_W-1:0] red, input logic [MASK_W-1:0] green,
                                input logic [MASK_W-1:0] blue);
        logic [CFG_IDX_W-1:0] spare;
        s_axis_tvalid <= 1'b0;
        while (pending_px.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        write_reg(CFG_BPP, CFG_DATA_W'(bpp));
        write_reg(CFG_PITCH, CFG_DATA_W'(pitch));
        write_reg(CFG_RED, red);
        write_reg(CFG_GREEN, green);
        write_reg(CFG_BLUE, blue);
        // A write to an index past the register list must change nothing.
        spare = CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO));
        write_reg(spare, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Called at a falling edge and returns at a falling edge.
    task automatic issue_pixel(input logic mode, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] pix,
                               input bit fixed, input logic [PIX_W-1:0] want_data,
                               input logic want_err);
        px_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - IN_USED_W){1'b0}}, pix, y, x, mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_access(mode, x, y, pix, res);
        if (fixed)
        begin
            res.read_data  = want_data;
            res.addr_error = want_err;
        end
        pending_px.push_back(res);
        if (res.addr_error)
            n_oor++;
        else if (mode == MODE_READ)
            n_reads++;
        else
            n_writes++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_armed && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_px.size() == 0)
            begin
                $error("unexpected result item %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                oldest_px = pending_px.pop_front();
                if (m_axis_tdata[PIX_W-1:0] !== oldest_px.read_data)
                begin
                    $error("read_data: expected %h, got %h", oldest_px.read_data,
                           m_axis_tdata[PIX_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tdata[PIX_W] !== oldest_px.addr_error)
                begin
                    $error("addr_error: expected %b, got %b", oldest_px.addr_error,
                           m_axis_tdata[PIX_W]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
                     pending_px.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   pix;
        logic [BPP_W-1:0]   bpp;
        logic [PITCH_W-1:0] pitch;
        logic [MASK_W-1:0]  red;
        logic [MASK_W-1:0]  green;
        logic [MASK_W-1:0]  blue;
        int                 two_seen;
        int                 phase;
        dir_row_t           r;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fmt_bpp       = BPP_RESET;
        fmt_pitch     = PITCH_RESET;
        fmt_red       = RED_RESET;
        fmt_green     = GREEN_RESET;
        fmt_blue      = BLUE_RESET;
        two_seen      = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset format: 4 bytes per pixel, 256-byte rows, so (63,63) is the last pixel.
        row_fix(MODE_WRITE, 0, 0, 32'hFF12_3456, '0, 1'b0);
        row_fix(MODE_READ, 0, 0, '0, 32'hFF12_3456, 1'b0);
        row_fix(MODE_WRITE, 1, 0, 32'hFFFF_FFFF, '0, 1'b0);
        row_px(MODE_WRITE, 1, 0, 32'h0000_0000);
        row_px(MODE_READ, 1, 0, 32'hFFFF_FFFF);
        row_px(MODE_WRITE, 0, 0, 32'h80A0_B0C0);
        row_px(MODE_READ, 0, 0, '0);
        row_fix(MODE_WRITE, 63, 63, 32'hFF00_AA55, '0, 1'b0);
        row_fix(MODE_READ, 63, 63, '0, 32'hFF00_AA55, 1'b0);
        row_fix(MODE_READ, 64, 63, '0, '0, 1'b1);
        row_fix(MODE_WRITE, 4095, 4095, 32'hFFFF_FFFF, '0, 1'b1);
        row_cfg(BPP_TWO, PITCH_RESET, RED_RESET, GREEN_RESET, BLUE_RESET);
        row_fix(MODE_WRITE, 0, 0, 32'hFFFF_1234, '0, 1'b0);
        row_px(MODE_WRITE, 0, 0, 32'h7F00_ABCD);
        row_px(MODE_READ, 0, 0, '0);
        // Overlapping and sparse masks in the 16-bit blend.
        row_cfg(BPP_TWO, PITCH_RESET, 16'hFFFF, 16'h0000, 16'h8001);
        row_px(MODE_WRITE, 0, 0, 32'h40FF_FFFF);
        row_px(MODE_READ, 0, 0, '0);
        row_cfg(3'd3, 15'd1, RED_RESET, GREEN_RESET, BLUE_RESET);
        row_fix(MODE_WRITE, 2, 0, 32'hFF00_C0DE, '0, 1'b0);
        row_fix(MODE_READ, 2, 0, '0, 32'h0000_C0DE, 1'b0);
        row_px(MODE_WRITE, 2, 0, 32'h3012_3456);
        row_px(MODE_READ, 2, 0, '0);
        // One byte per pixel is always stored directly, whatever the alpha.
        row_cfg(BPP_ONE, 15'd16384, RED_RESET, GREEN_RESET, BLUE_RESET);
        row_fix(MODE_WRITE, 5, 0, 32'h0000_0081, '0, 1'b0);
        row_fix(MODE_READ, 5, 0, '0, 32'h0000_0081, 1'b0);
        row_fix(MODE_READ, 0, 1, '0, '0, 1'b1);
        // No valid format: no access and no error, even far out of range.
        row_cfg(3'd0, PITCH_RESET, RED_RESET, GREEN_RESET, BLUE_RESET);
        row_fix(MODE_WRITE, 4095, 4095, 32'hFFFF_FFFF, '0, 1'b0);
        row_fix(MODE_READ, 0, 0, '0, '0, 1'b0);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.is_cfg)
                apply_config(r.bpp, r.pitch, r.red, r.green, r.blue);
            else
                issue_pixel(r.mode, r.x, r.y, r.pix, r.fixed, r.want_data, r.want_err);
        end

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            bpp = PHASE_BPP[phase];
            case (phase % 4)
                0:       pitch = 15'd1;
                1:       pitch = 15'd16384;
                2:       pitch = PITCH_RESET;
                default: pitch = PITCH_W'($urandom_range(300, 2));
            endcase
            red   = MASK_W'($urandom);
            green = MASK_W'($urandom);
            blue  = MASK_W'($urandom);
            if (bpp == BPP_TWO)
            begin
                case (two_seen % 4)
                    0:
                    begin
                        red   = RED_RESET;
                        green = GREEN_RESET;
                        blue  = BLUE_RESET;
                    end
                    1:
                    begin
                        red   = 16'hFFFF;
                        green = 16'hFFFF;
                        blue  = 16'hFFFF;
                    end
                    2:
                    begin
                        red   = 16'h0000;
                        green = 16'h0000;
                        blue  = 16'h0000;
                    end
                    default: ;
                endcase
                two_seen++;
            end
            apply_config(bpp, pitch, red, green, blue);
            if (phase < 5)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 59;
            end
            else if (phase < 10)
            begin
                send_idle_pct = 59;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_armed    = 1'b1;
            end
            repeat ((bpp >= BPP_MIN && bpp <= BPP_MAX) ? VALID_ITEMS : NOFMT_ITEMS)
            begin
                random_pixel(mode, x, y, pix);
                issue_pixel(mode, x, y, pix, 1'b0, '0, 1'b0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_px.size() != 0)
            @(negedge clk);
        repeat (12) @(posedge clk);

        $display("Run covered %0d reads, %0d writes and %0d out-of-range items", n_reads,
                 n_writes, n_oor);
        $display("over %0d register settings, including all pixel formats; %0d mismatches",
                 n_settings, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
